@@ hdl/vfcm_pkg.sv @@
// vfcm_pkg: shared types, codes and face geometry for the voxel face culling mesher
// no dependencies; used by vfcm_ram and voxel_face_culling_mesher_top
package vfcm_pkg;

    // default chunk geometry
    localparam int CHUNK_SIDE_DEF = 16;
    localparam int CELLS_DEF      = CHUNK_SIDE_DEF * CHUNK_SIDE_DEF * CHUNK_SIDE_DEF;

    // fixed field widths
    localparam int IDX_W   = 12;
    localparam int COORD_W = 7;
    localparam int COUNT_W = 17;

    // command codes
    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_QUERY = 2'd1,
        FN_CLEAR = 2'd2
    } t_func;

    // face directions
    localparam logic [2:0] DIR_PX = 3'd0;
    localparam logic [2:0] DIR_NX = 3'd1;
    localparam logic [2:0] DIR_PY = 3'd2;
    localparam logic [2:0] DIR_NY = 3'd3;
    localparam logic [2:0] DIR_PZ = 3'd4;
    localparam logic [2:0] DIR_NZ = 3'd5;

    // scan slots: center cell first, then one per face
    localparam logic [2:0] SLOT_CENTER = 3'd0;
    localparam logic [2:0] SLOT_LAST   = 3'd6;

    localparam logic [1:0] VERT_LAST = 2'd3;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_DIV3,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef logic signed [2:0] t_ofs;

    typedef struct packed {
        t_ofs x;
        t_ofs y;
        t_ofs z;
    } t_ofs3;

    // corner offset of vertex k on face dir, in half units: n + p_k
    function automatic t_ofs3 f_offset(input logic [2:0] dir, input logic [1:0] k);
        int n0, n1, n2;
        int a0, a1, a2;
        int b0, b1, b2;
        t_ofs3 r;
        n0 = 0;
        n1 = 0;
        n2 = 0;
        case (dir)
            DIR_PX:  n0 = 1;
            DIR_NX:  n0 = -1;
            DIR_PY:  n1 = 1;
            DIR_NY:  n1 = -1;
            DIR_PZ:  n2 = 1;
            DIR_NZ:  n2 = -1;
            default: n0 = 0;
        endcase
        // p0 = n x (1,1,1)
        a0 = n1 - n2;
        a1 = n2 - n0;
        a2 = n0 - n1;
        // p1 = n x p0
        b0 = n1 * a2 - a1 * n2;
        b1 = n2 * a0 - a2 * n0;
        b2 = n0 * a1 - a0 * n1;
        unique case (k)
            2'd0: r = '{t_ofs'(n0 + a0), t_ofs'(n1 + a1), t_ofs'(n2 + a2)};
            2'd1: r = '{t_ofs'(n0 + b0), t_ofs'(n1 + b1), t_ofs'(n2 + b2)};
            2'd2: r = '{t_ofs'(n0 - a0), t_ofs'(n1 - a1), t_ofs'(n2 - a2)};
            2'd3: r = '{t_ofs'(n0 - b0), t_ofs'(n1 - b1), t_ofs'(n2 - b2)};
        endcase
        return r;
    endfunction

    // texture corner {u, v} of vertex k on face dir
    function automatic logic [1:0] f_uv(input logic [2:0] dir, input logic [1:0] k);
        logic [1:0] r;
        case (dir)
            DIR_NX, DIR_NY, DIR_PZ: begin
                unique case (k)
                    2'd0: r = 2'b00;
                    2'd1: r = 2'b01;
                    2'd2: r = 2'b11;
                    2'd3: r = 2'b10;
                endcase
            end
            DIR_PY: begin
                unique case (k)
                    2'd0: r = 2'b10;
                    2'd1: r = 2'b00;
                    2'd2: r = 2'b01;
                    2'd3: r = 2'b11;
                endcase
            end
            default: begin
                unique case (k)
                    2'd0: r = 2'b01;
                    2'd1: r = 2'b11;
                    2'd2: r = 2'b10;
                    2'd3: r = 2'b00;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

@@ hdl/vfcm_ram.sv @@
// vfcm_ram: generic single write port, single read port RAM with registered read
// depends on vfcm_pkg for the default depth
module vfcm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = vfcm_pkg::CELLS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/voxel_face_culling_mesher_top.sv @@
// voxel_face_culling_mesher_top: solid map in RAM, neighbor scan and face vertex emitter
// depends on vfcm_pkg and vfcm_ram
//
//  channel   handshake            word
//  command   start / busy         i_func, i_cell_index, i_cell_solid
//  vertex    o_valid (strobe)     o_vertex_x2/y2/z2, o_face_dir, o_tex_u, o_tex_v,
//                                 o_vertex_number, o_last
//
// write and clear-count commands leave busy low.
// a query holds busy through the index decode states ST_DIV1, ST_DIV2 and ST_DIV3, seven
// RAM reads (center then six neighbors, one port, one per cycle), a drain state that takes
// the last read and decides, then one vertex per cycle, four for each exposed face (at most
// six). each vertex word is registered and appears in the cycle after it is formed. after
// reset a clearing pass writes air to all CHUNK_SIDE^3 cells with busy high. vertices are
// never held.
module voxel_face_culling_mesher_top #(
    parameter int CHUNK_SIDE = vfcm_pkg::CHUNK_SIDE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_func,
    input  logic [vfcm_pkg::IDX_W-1:0]       i_cell_index,
    input  logic                             i_cell_solid,
    output logic                             o_valid,
    output logic signed [vfcm_pkg::COORD_W-1:0] o_vertex_x2,
    output logic signed [vfcm_pkg::COORD_W-1:0] o_vertex_y2,
    output logic signed [vfcm_pkg::COORD_W-1:0] o_vertex_z2,
    output logic [2:0]                       o_face_dir,
    output logic                             o_tex_u,
    output logic                             o_tex_v,
    output logic [vfcm_pkg::COUNT_W-1:0]     o_vertex_number,
    output logic                             o_last
);

    localparam int IW    = vfcm_pkg::IDX_W;
    localparam int CRW   = vfcm_pkg::COORD_W;
    localparam int CTW   = vfcm_pkg::COUNT_W;
    localparam int CELLS = CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CHUNK_SIDE);
    // reciprocal for exact division of an IW-bit value by CHUNK_SIDE
    localparam int SHIFT = IW + CW;
    localparam int RW    = IW + 1;
    localparam int RECIP = ((2 ** SHIFT) + CHUNK_SIDE - 1) / CHUNK_SIDE;
    localparam logic [RW-1:0] RECIP_V  = RW'(RECIP);
    localparam logic [IW-1:0] SIDE_IDX = IW'(CHUNK_SIDE);
    localparam logic [CW-1:0] CMAX     = CW'(CHUNK_SIDE - 1);
    localparam logic [AW-1:0] STEP_X   = AW'(CHUNK_SIDE);
    localparam logic [AW-1:0] STEP_Z   = AW'(CHUNK_SIDE * CHUNK_SIDE);
    localparam logic [AW-1:0] ADDR_END = AW'(CELLS - 1);

    vfcm_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [IW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_addr, n_addr;
    logic [IW-1:0]    r_q1, n_q1;
    logic [IW-1:0]    r_q2, n_q2;
    logic [CW-1:0]    r_x, n_x;
    logic [CW-1:0]    r_y, n_y;
    logic [CW-1:0]    r_z, n_z;
    logic [2:0]       r_slot, n_slot;
    logic             r_pend_valid, n_pend_valid;
    logic [2:0]       r_pend_slot, n_pend_slot;
    logic             r_pend_oob, n_pend_oob;
    logic             r_solid, n_solid;
    logic [5:0]       r_open, n_open;
    logic [1:0]       r_k, n_k;
    logic [CTW-1:0]   r_count, n_count;
    logic             r_ovalid, n_ovalid;
    logic [CRW-1:0]   r_ox, n_ox;
    logic [CRW-1:0]   r_oy, n_oy;
    logic [CRW-1:0]   r_oz, n_oz;
    logic [2:0]       r_odir, n_odir;
    logic             r_ou, n_ou;
    logic             r_ov, n_ov;
    logic [CTW-1:0]   r_onum, n_onum;
    logic             r_olast, n_olast;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic             ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic             ram_rdata;

    logic             in_range;
    logic [IW+RW-1:0] prod1, prod2;
    logic [2:0]       scan_dir, pend_dir;
    logic             scan_oob;
    logic [2:0]       cur_dir;
    logic [5:0]       rest;
    vfcm_pkg::t_ofs3  ofs;
    logic [1:0]       uv;

    // solid map
    vfcm_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_range = (32'(i_cell_index) < 32'(CELLS));
    assign prod1    = r_idx * RECIP_V;
    assign prod2    = r_q1 * RECIP_V;
    assign scan_dir = 3'(r_slot - 3'd1);
    assign pend_dir = 3'(r_pend_slot - 3'd1);

    // neighbor address and chunk bound for the current scan slot
    always_comb begin
        ram_raddr = r_addr;
        scan_oob  = 1'b0;
        if (r_slot != vfcm_pkg::SLOT_CENTER) begin
            case (scan_dir)
                vfcm_pkg::DIR_PX: begin
                    ram_raddr = r_addr + STEP_X;
                    scan_oob  = (r_x == CMAX);
                end
                vfcm_pkg::DIR_NX: begin
                    ram_raddr = r_addr - STEP_X;
                    scan_oob  = (r_x == '0);
                end
                vfcm_pkg::DIR_PY: begin
                    ram_raddr = r_addr + AW'(1);
                    scan_oob  = (r_y == CMAX);
                end
                vfcm_pkg::DIR_NY: begin
                    ram_raddr = r_addr - AW'(1);
                    scan_oob  = (r_y == '0);
                end
                vfcm_pkg::DIR_PZ: begin
                    ram_raddr = r_addr + STEP_Z;
                    scan_oob  = (r_z == CMAX);
                end
                vfcm_pkg::DIR_NZ: begin
                    ram_raddr = r_addr - STEP_Z;
                    scan_oob  = (r_z == '0);
                end
                default: begin
                    ram_raddr = r_addr;
                    scan_oob  = 1'b0;
                end
            endcase
        end
    end

    // lowest open face and the faces left after it
    always_comb begin
        cur_dir = '0;
        for (int i = 5; i >= 0; i--) begin
            if (r_open[i]) begin
                cur_dir = 3'(i);
            end
        end
        for (int i = 0; i < 6; i++) begin
            rest[i] = r_open[i] && (3'(i) != cur_dir);
        end
        ofs = vfcm_pkg::f_offset(cur_dir, r_k);
        uv  = vfcm_pkg::f_uv(cur_dir, r_k);
    end

    // next state and datapath
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_idx        = r_idx;
        n_addr       = r_addr;
        n_q1         = r_q1;
        n_q2         = r_q2;
        n_x          = r_x;
        n_y          = r_y;
        n_z          = r_z;
        n_slot       = r_slot;
        n_pend_valid = 1'b0;
        n_pend_slot  = r_pend_slot;
        n_pend_oob   = r_pend_oob;
        n_solid      = r_solid;
        n_open       = r_open;
        n_k          = r_k;
        n_count      = r_count;
        n_ovalid     = 1'b0;
        n_ox         = r_ox;
        n_oy         = r_oy;
        n_oz         = r_oz;
        n_odir       = r_odir;
        n_ou         = r_ou;
        n_ov         = r_ov;
        n_onum       = r_onum;
        n_olast      = r_olast;
        ram_we       = 1'b0;
        ram_waddr    = r_clr;
        ram_wdata    = 1'b0;

        unique case (r_state)
            vfcm_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + AW'(1);
                if (r_clr == ADDR_END) begin
                    n_state = vfcm_pkg::ST_IDLE;
                end
            end
            vfcm_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_func)
                        vfcm_pkg::FN_WRITE: begin
                            ram_we    = in_range;
                            ram_waddr = AW'(i_cell_index);
                            ram_wdata = i_cell_solid;
                        end
                        vfcm_pkg::FN_QUERY: begin
                            if (in_range) begin
                                n_idx   = i_cell_index;
                                n_addr  = AW'(i_cell_index);
                                n_state = vfcm_pkg::ST_DIV1;
                            end
                        end
                        vfcm_pkg::FN_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_state = vfcm_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            // idx / side
            vfcm_pkg::ST_DIV1: begin
                n_q1    = IW'(prod1 >> SHIFT);
                n_open  = '0;
                n_solid = 1'b0;
                n_state = vfcm_pkg::ST_DIV2;
            end
            // y = idx mod side, q2 = z
            vfcm_pkg::ST_DIV2: begin
                n_y     = CW'(r_idx - IW'(r_q1 * SIDE_IDX));
                n_q2    = IW'(prod2 >> SHIFT);
                n_state = vfcm_pkg::ST_DIV3;
            end
            vfcm_pkg::ST_DIV3: begin
                n_x     = CW'(r_q1 - IW'(r_q2 * SIDE_IDX));
                n_z     = CW'(r_q2);
                n_slot  = vfcm_pkg::SLOT_CENTER;
                n_state = vfcm_pkg::ST_SCAN;
            end
            // one read per cycle: center, then +x,-x,+y,-y,+z,-z
            vfcm_pkg::ST_SCAN: begin
                n_pend_valid = 1'b1;
                n_pend_slot  = r_slot;
                n_pend_oob   = scan_oob;
                if (r_slot == vfcm_pkg::SLOT_LAST) begin
                    n_state = vfcm_pkg::ST_DRAIN;
                end else begin
                    n_slot = r_slot + 3'd1;
                end
            end
            // the -z read lands in this cycle and counts in the decision
            vfcm_pkg::ST_DRAIN: begin
                if (r_solid && ((r_open != '0) || r_pend_oob || !ram_rdata)) begin
                    n_k     = '0;
                    n_state = vfcm_pkg::ST_EMIT;
                end else begin
                    n_state = vfcm_pkg::ST_IDLE;
                end
            end
            // one vertex per cycle over the open faces
            vfcm_pkg::ST_EMIT: begin
                n_ovalid = 1'b1;
                n_ox     = CRW'({r_x, 1'b0}) + CRW'(ofs.x);
                n_oy     = CRW'({r_y, 1'b0}) + CRW'(ofs.y);
                n_oz     = CRW'({r_z, 1'b0}) + CRW'(ofs.z);
                n_odir   = cur_dir;
                n_ou     = uv[1];
                n_ov     = uv[0];
                n_onum   = r_count;
                n_count  = r_count + CTW'(1);
                n_olast  = (r_k == vfcm_pkg::VERT_LAST) && (rest == '0);
                n_k      = r_k + 2'd1;
                if (r_k == vfcm_pkg::VERT_LAST) begin
                    n_open = rest;
                    if (rest == '0) begin
                        n_state = vfcm_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = vfcm_pkg::ST_IDLE;
            end
        endcase

        // collect the read issued in the previous cycle
        if (r_pend_valid) begin
            if (r_pend_slot == vfcm_pkg::SLOT_CENTER) begin
                n_solid = ram_rdata;
            end else begin
                n_open[pend_dir] = r_pend_oob | ~ram_rdata;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= vfcm_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_pend_valid <= 1'b0;
            r_count      <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_pend_valid <= n_pend_valid;
            r_count      <= n_count;
            r_ovalid     <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_addr      <= n_addr;
        r_q1        <= n_q1;
        r_q2        <= n_q2;
        r_x         <= n_x;
        r_y         <= n_y;
        r_z         <= n_z;
        r_slot      <= n_slot;
        r_pend_slot <= n_pend_slot;
        r_pend_oob  <= n_pend_oob;
        r_solid     <= n_solid;
        r_open      <= n_open;
        r_k         <= n_k;
        r_ox        <= n_ox;
        r_oy        <= n_oy;
        r_oz        <= n_oz;
        r_odir      <= n_odir;
        r_ou        <= n_ou;
        r_ov        <= n_ov;
        r_onum      <= n_onum;
        r_olast     <= n_olast;
    end

    // ports
    assign busy            = (r_state != vfcm_pkg::ST_IDLE);
    assign o_valid         = r_ovalid;
    assign o_vertex_x2     = $signed(r_ox);
    assign o_vertex_y2     = $signed(r_oy);
    assign o_vertex_z2     = $signed(r_oz);
    assign o_face_dir      = r_odir;
    assign o_tex_u         = r_ou;
    assign o_tex_v         = r_ov;
    assign o_vertex_number = r_onum;
    assign o_last          = r_olast;

    // a vertex word only follows an emit cycle
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> ($past(r_state) == vfcm_pkg::ST_EMIT))
        else $error("vertex word without emit cycle");

    // emitting needs a solid center and at least one open face
    a_emit_has_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vfcm_pkg::ST_EMIT) |-> (r_solid && (r_open != '0)))
        else $error("emit with no face left");

    // the count advances by one with each vertex word
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_count == CTW'($past(r_count) + CTW'(1))))
        else $error("vertex count out of step");

    // the final vertex of a query is not followed at once by another
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |=> !r_ovalid)
        else $error("vertex after last");

    // the map is written only while clearing or idle
    a_write_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == vfcm_pkg::ST_CLEAR) || (r_state == vfcm_pkg::ST_IDLE)))
        else $error("map write during query");

endmodule

@@ tb/vfcm_vertex_checker.sv @@
// vfcm_vertex_checker: watches the command and vertex channels of the mesher,
// keeps its own solid map and vertex count, and compares every vertex word
// depends on vfcm_pkg
module vfcm_vertex_checker #(
    parameter int CHUNK_SIDE = vfcm_pkg::CHUNK_SIDE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic [1:0]                          i_func,
    input  logic [vfcm_pkg::IDX_W-1:0]          i_cell_index,
    input  logic                                i_cell_solid,
    input  logic                                i_valid,
    input  logic signed [vfcm_pkg::COORD_W-1:0] i_vertex_x2,
    input  logic signed [vfcm_pkg::COORD_W-1:0] i_vertex_y2,
    input  logic signed [vfcm_pkg::COORD_W-1:0] i_vertex_z2,
    input  logic [2:0]                          i_face_dir,
    input  logic                                i_tex_u,
    input  logic                                i_tex_v,
    input  logic [vfcm_pkg::COUNT_W-1:0]        i_vertex_number,
    input  logic                                i_last,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int CELLS = CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE;
    localparam int REPORT_MAX = 10;
    localparam int CRW = vfcm_pkg::COORD_W;
    localparam int CTW = vfcm_pkg::COUNT_W;

    typedef struct {
        logic signed [CRW-1:0] x2;
        logic signed [CRW-1:0] y2;
        logic signed [CRW-1:0] z2;
        logic [2:0]            dir;
        logic                  u;
        logic                  v;
        logic [CTW-1:0]        number;
        logic                  last;
    } t_vertex;

    t_vertex            vertex_q[$];
    bit                 cell_is_solid[CELLS];
    logic [CTW-1:0]     vertex_count;
    int                 mismatch_count;

    // cells outside the chunk count as air
    function automatic bit neighbor_open(int x, int y, int z);
        if (x < 0 || y < 0 || z < 0 || x >= CHUNK_SIDE || y >= CHUNK_SIDE || z >= CHUNK_SIDE)
            return 1'b1;
        return !cell_is_solid[(z * CHUNK_SIDE + x) * CHUNK_SIDE + y];
    endfunction

    // queue the four corners of every exposed face of a solid cell
    function automatic void predict_faces(int idx);
        int px, py, pz;
        int nx, ny, nz;
        int ax, ay, az;
        int bx, by, bz;
        int sx, sy, sz;
        int corner, first;
        t_vertex vtx;
        py = idx % CHUNK_SIDE;
        px = (idx / CHUNK_SIDE) % CHUNK_SIDE;
        pz = idx / (CHUNK_SIDE * CHUNK_SIDE);
        first = vertex_q.size();
        for (int d = 0; d < 6; d++) begin
            nx = (d == vfcm_pkg::DIR_PX) ? 1 : (d == vfcm_pkg::DIR_NX) ? -1 : 0;
            ny = (d == vfcm_pkg::DIR_PY) ? 1 : (d == vfcm_pkg::DIR_NY) ? -1 : 0;
            nz = (d == vfcm_pkg::DIR_PZ) ? 1 : (d == vfcm_pkg::DIR_NZ) ? -1 : 0;
            if (!neighbor_open(px + nx, py + ny, pz + nz))
                continue;
            // first corner: n crossed with (1,1,1)
            ax = ny - nz;
            ay = nz - nx;
            az = nx - ny;
            // second corner: n crossed with the first
            bx = ny * az - nz * ay;
            by = nz * ax - nx * az;
            bz = nx * ay - ny * ax;
            for (int k = 0; k < 4; k++) begin
                case (k)
                    0: begin sx = ax;  sy = ay;  sz = az;  end
                    1: begin sx = bx;  sy = by;  sz = bz;  end
                    2: begin sx = -ax; sy = -ay; sz = -az; end
                    default: begin sx = -bx; sy = -by; sz = -bz; end
                endcase
                // base uv corners (0,1),(1,1),(1,0),(0,0), shifted per normal
                if (nx < 0 || ny < 0 || nz > 0)
                    corner = (k + 3) % 4;
                else if (ny > 0)
                    corner = (k + 2) % 4;
                else
                    corner = k;
                vtx.x2     = CRW'(2 * px + nx + sx);
                vtx.y2     = CRW'(2 * py + ny + sy);
                vtx.z2     = CRW'(2 * pz + nz + sz);
                vtx.dir    = 3'(d);
                vtx.u      = (corner == 1 || corner == 2);
                vtx.v      = (corner < 2);
                vtx.number = vertex_count;
                vtx.last   = 1'b0;
                vertex_q.push_back(vtx);
                vertex_count = vertex_count + 1'b1;
            end
        end
        if (vertex_q.size() > first)
            vertex_q[vertex_q.size() - 1].last = 1'b1;
    endfunction

    function automatic string show(t_vertex w);
        return $sformatf("pos (%0d,%0d,%0d) dir %0d uv %0d%0d num %0d last %0d",
                         w.x2, w.y2, w.z2, w.dir, w.u, w.v, w.number, w.last);
    endfunction

    // compare vertex words, then apply the accepted command word
    always @(posedge i_clk) begin
        t_vertex got;
        t_vertex want;
        if (!i_rst_n) begin
            for (int c = 0; c < CELLS; c++)
                cell_is_solid[c] = 1'b0;
            vertex_count = '0;
            vertex_q.delete();
            o_fail_count = 0;
            mismatch_count = 0;
        end else begin
            if (i_valid) begin
                got.x2     = i_vertex_x2;
                got.y2     = i_vertex_y2;
                got.z2     = i_vertex_z2;
                got.dir    = i_face_dir;
                got.u      = i_tex_u;
                got.v      = i_tex_v;
                got.number = i_vertex_number;
                got.last   = i_last;
                if (vertex_q.size() == 0) begin
                    o_fail_count++;
                    if (mismatch_count++ < REPORT_MAX)
                        $display("unexpected vertex word: got %s", show(got));
                end else begin
                    want = vertex_q.pop_front();
                    if (got.x2 !== want.x2 || got.y2 !== want.y2 || got.z2 !== want.z2 ||
                        got.dir !== want.dir || got.u !== want.u || got.v !== want.v ||
                        got.number !== want.number || got.last !== want.last) begin
                        o_fail_count++;
                        if (mismatch_count++ < REPORT_MAX)
                            $display("vertex mismatch: expected %s, got %s",
                                     show(want), show(got));
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_func)
                    vfcm_pkg::FN_WRITE: begin
                        if (i_cell_index < CELLS)
                            cell_is_solid[i_cell_index] = i_cell_solid;
                    end
                    vfcm_pkg::FN_QUERY: begin
                        if (i_cell_index < CELLS && cell_is_solid[i_cell_index])
                            predict_faces(i_cell_index);
                    end
                    vfcm_pkg::FN_CLEAR: vertex_count = '0;
                    default: ;
                endcase
            end
        end
        o_pending = vertex_q.size();
    end

endmodule

@@ tb/voxel_face_culling_mesher_top_tb.sv @@
// voxel_face_culling_mesher_top_tb: command stimulus and verdict for the mesher
// depends on vfcm_pkg, voxel_face_culling_mesher_top and vfcm_vertex_checker
module voxel_face_culling_mesher_top_tb;

    // spare command code, ignored by the block
    localparam logic [1:0] FN_SPARE = 2'd3;
    localparam int SIDE = vfcm_pkg::CHUNK_SIDE_DEF;
    localparam int CELL_COUNT = vfcm_pkg::CELLS_DEF;
    localparam int RANDOM_WORDS = 230;
    // back to back full-face queries on a lone cell
    localparam int BURST_QUERIES = 8;
    localparam int TAIL_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] func = vfcm_pkg::FN_WRITE;
    logic [vfcm_pkg::IDX_W-1:0] cell_index = '0;
    logic cell_solid = 1'b0;

    logic busy;
    logic valid;
    logic signed [vfcm_pkg::COORD_W-1:0] vertex_x2, vertex_y2, vertex_z2;
    logic [2:0] face_dir;
    logic tex_u, tex_v;
    logic [vfcm_pkg::COUNT_W-1:0] vertex_number;
    logic last;

    int fail_count;
    int pending;
    bit burst = 1'b0;
    int solid_cells[$];

    always #5 clk = ~clk;

    voxel_face_culling_mesher_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (func),
        .i_cell_index    (cell_index),
        .i_cell_solid    (cell_solid),
        .o_valid         (valid),
        .o_vertex_x2     (vertex_x2),
        .o_vertex_y2     (vertex_y2),
        .o_vertex_z2     (vertex_z2),
        .o_face_dir      (face_dir),
        .o_tex_u         (tex_u),
        .o_tex_v         (tex_v),
        .o_vertex_number (vertex_number),
        .o_last          (last)
    );

    vfcm_vertex_checker #(.CHUNK_SIDE(SIDE)) i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_func          (func),
        .i_cell_index    (cell_index),
        .i_cell_solid    (cell_solid),
        .i_valid         (valid),
        .i_vertex_x2     (vertex_x2),
        .i_vertex_y2     (vertex_y2),
        .i_vertex_z2     (vertex_z2),
        .i_face_dir      (face_dir),
        .i_tex_u         (tex_u),
        .i_tex_v         (tex_v),
        .i_vertex_number (vertex_number),
        .i_last          (last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    function automatic int cell_at(int x, int y, int z);
        return (z * SIDE + x) * SIDE + y;
    endfunction

    // coordinate on or next to a chunk wall
    function automatic int wall_coord();
        return $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(SIDE - 2, SIDE - 1);
    endfunction

    // mix of anywhere, near the walls and a dense middle cluster
    function automatic int pick_cell();
        case ($urandom_range(0, 2))
            0: return $urandom_range(0, CELL_COUNT - 1);
            1: return cell_at(wall_coord(), wall_coord(), wall_coord());
            default: return cell_at($urandom_range(6, 8), $urandom_range(6, 8),
                                    $urandom_range(6, 8));
        endcase
    endfunction

    // present one command word and hold it until accepted
    task automatic send_word(input logic [1:0] f, input int idx, input logic solid);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        func       <= f;
        cell_index <= idx[vfcm_pkg::IDX_W-1:0];
        cell_solid <= solid;
        do @(posedge clk); while (busy);
    endtask

    // stimulus and verdict
    initial begin
        int center;
        int idx;
        int pick;
        logic solid;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty cell, corner and far cells, neighbor culling
        send_word(vfcm_pkg::FN_QUERY, 0, 1'b0);
        send_word(vfcm_pkg::FN_WRITE, 0, 1'b1);
        send_word(vfcm_pkg::FN_QUERY, 0, 1'b0);
        send_word(vfcm_pkg::FN_WRITE, CELL_COUNT - 1, 1'b1);
        send_word(vfcm_pkg::FN_QUERY, CELL_COUNT - 1, 1'b0);
        send_word(vfcm_pkg::FN_WRITE, cell_at(0, 1, 0), 1'b1);
        send_word(vfcm_pkg::FN_QUERY, 0, 1'b0);
        send_word(FN_SPARE, CELL_COUNT - 1, 1'b1);
        send_word(vfcm_pkg::FN_CLEAR, 0, 1'b0);

        // fully enclosed cell gives nothing, a side neighbor gives five faces
        center = cell_at(5, 5, 5);
        send_word(vfcm_pkg::FN_WRITE, center, 1'b1);
        send_word(vfcm_pkg::FN_WRITE, center + 1, 1'b1);
        send_word(vfcm_pkg::FN_WRITE, center - 1, 1'b1);
        send_word(vfcm_pkg::FN_WRITE, center + SIDE, 1'b1);
        send_word(vfcm_pkg::FN_WRITE, center - SIDE, 1'b1);
        send_word(vfcm_pkg::FN_WRITE, center + SIDE * SIDE, 1'b1);
        send_word(vfcm_pkg::FN_WRITE, center - SIDE * SIDE, 1'b1);
        send_word(vfcm_pkg::FN_QUERY, center, 1'b0);
        send_word(vfcm_pkg::FN_QUERY, center + 1, 1'b0);
        send_word(vfcm_pkg::FN_WRITE, CELL_COUNT - 1, 1'b0);
        send_word(vfcm_pkg::FN_QUERY, CELL_COUNT - 1, 1'b0);
        send_word(vfcm_pkg::FN_WRITE, 0, 1'b0);

        // full-face queries on a lone cell, back to back
        idx = cell_at(10, 10, 10);
        send_word(vfcm_pkg::FN_CLEAR, idx, 1'b0);
        send_word(vfcm_pkg::FN_WRITE, idx, 1'b1);
        burst = 1'b1;
        for (int q = 0; q < BURST_QUERIES; q++)
            send_word(vfcm_pkg::FN_QUERY, idx, 1'b0);
        burst = 1'b0;

        // random traffic: mostly writes and queries around solid cells
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
                idx = pick_cell();
                solid = ($urandom_range(0, 9) < 7);
                if (solid) begin
                    solid_cells.push_back(idx);
                    if (solid_cells.size() > 64)
                        void'(solid_cells.pop_front());
                end
                send_word(vfcm_pkg::FN_WRITE, idx, solid);
            end else if (pick < 90) begin
                if (solid_cells.size() > 0 && $urandom_range(0, 1))
                    idx = solid_cells[$urandom_range(0, solid_cells.size() - 1)];
                else
                    idx = pick_cell();
                send_word(vfcm_pkg::FN_QUERY, idx, 1'($urandom_range(0, 1)));
            end else if (pick < 95) begin
                send_word(vfcm_pkg::FN_CLEAR, $urandom_range(0, CELL_COUNT - 1),
                          1'($urandom_range(0, 1)));
            end else begin
                send_word(FN_SPARE, $urandom_range(0, CELL_COUNT - 1), 1'($urandom_range(0, 1)));
            end
        end
        start <= 1'b0;

        // drain outstanding vertices, then a short quiet tail
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS voxel_face_culling_mesher_top");
        else
            $display("FAIL voxel_face_culling_mesher_top");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("FAIL voxel_face_culling_mesher_top");
        $finish;
    end

endmodule

@@ files.f @@
hdl/vfcm_pkg.sv
hdl/vfcm_ram.sv
hdl/voxel_face_culling_mesher_top.sv
tb/vfcm_vertex_checker.sv
tb/voxel_face_culling_mesher_top_tb.sv
